// ----- src/cefm_pkg.sv -----
// shared constants for the capture edge frequency meter
package cefm_pkg;

    localparam int unsigned CLK_W      = 32;
    localparam int unsigned CAP_W      = 16;
    localparam int unsigned CAP_EXT_W  = 32;
    localparam int unsigned FREQ_W     = 31;
    localparam int unsigned DIV_CNT_W  = $clog2(CLK_W);

    localparam logic [CLK_W-1:0] CLOCK_RESET = 32'd168000000;

    // handshake between the sequencer and the divider
    typedef struct packed {
        logic start;
    } div_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ----- src/cefm_div.sv -----
// radix-2 restoring divider, one quotient bit per cycle
module cefm_div #(
    parameter int unsigned DVS_W = 17
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  cefm_pkg::div_req_t            req,
    input  logic [cefm_pkg::CLK_W-1:0]    dividend,
    input  logic [DVS_W-1:0]              divisor,
    output cefm_pkg::div_stat_t           stat,
    output logic [cefm_pkg::CLK_W-1:0]    quotient
);
    import cefm_pkg::*;

    logic [CLK_W-1:0]     dvd_reg, dvd_next;
    logic [DVS_W-1:0]     dvs_reg, dvs_next;
    logic [DVS_W-1:0]     rem_reg, rem_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DVS_W:0]       trial;
    logic [DVS_W:0]       diff;

    // shift in the next dividend bit and try a subtract
    assign trial = {rem_reg, dvd_reg[CLK_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb begin
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            dvd_next  = dividend;
            dvs_next  = divisor;
            rem_next  = '0;
            cnt_next  = DIV_CNT_W'(CLK_W - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (diff[DVS_W]) begin
                rem_next = trial[DVS_W-1:0];
                dvd_next = {dvd_reg[CLK_W-2:0], 1'b0};
            end else begin
                rem_next = diff[DVS_W-1:0];
                dvd_next = {dvd_reg[CLK_W-2:0], 1'b1};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = dvd_reg;

    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |-> !busy_reg)
        else $error("divider started while busy");

    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(busy_reg) && !busy_reg)
        else $error("divider done without a run");

    a_last_step: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && cnt_reg == '0 && !req.start |=> done_reg)
        else $error("divider missed its final step");

endmodule

// ----- src/capture_edge_frequency_meter.sv -----
// top level: three-phase edge capture sequencer and frequency output register
// sequence: edge beats in PH_FIRST and PH_SECOND finish with no result; a PH_THIRD edge
// beat starts the divider, and the sequencer waits in ST_DIV until the divider is done,
// then loads the output register in ST_OUT once the slot is free; a zero sum skips ST_DIV
// throughput: s_ready stays low from a PH_THIRD edge beat until its result is loaded; reset
// (aresetn low, synchronous) clears phase, timestamps, valid flags, clock register to 168 MHz
module capture_edge_frequency_meter #(
    parameter int unsigned COUNTER_BITS = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration write channel
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [cefm_pkg::CLK_W-1:0]     cfg_data,
    // capture beats
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [cefm_pkg::CAP_W-1:0]     s_capture_value,
    // result beats
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [cefm_pkg::FREQ_W-1:0]    m_frequency_hz,
    output logic                           m_zero_interval
);
    import cefm_pkg::*;

    localparam int unsigned SUM_W = COUNTER_BITS + 1;

    typedef enum logic [1:0] {
        PH_FIRST,
        PH_SECOND,
        PH_THIRD
    } phase_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_OUT
    } state_t;

    state_t                  state_reg, state_next;
    phase_t                  phase_reg, phase_next;
    logic [COUNTER_BITS-1:0] last_ts_reg, last_ts_next;
    logic [COUNTER_BITS-1:0] first_iv_reg, first_iv_next;
    logic [CLK_W-1:0]        clock_hz_reg, clock_hz_next;
    logic                    zero_pend_reg, zero_pend_next;
    logic                    m_valid_reg, m_valid_next;
    logic [FREQ_W-1:0]       m_freq_reg, m_freq_next;
    logic                    m_zero_reg, m_zero_next;

    logic [CAP_EXT_W-1:0]    cap_ext;
    logic [COUNTER_BITS-1:0] cap_w;
    logic [COUNTER_BITS-1:0] second_iv;
    logic [SUM_W-1:0]        iv_sum;
    logic                    sum_zero;
    logic                    s_beat;
    logic                    out_free;

    div_req_t                div_req;
    div_stat_t               div_stat;
    logic [CLK_W-1:0]        div_quot;

    // capture taken modulo the counter width
    assign cap_ext   = {{(CAP_EXT_W - CAP_W){1'b0}}, s_capture_value};
    assign cap_w     = cap_ext[COUNTER_BITS-1:0];
    assign second_iv = cap_w - last_ts_reg;
    assign iv_sum    = {1'b0, first_iv_reg} + {1'b0, second_iv};
    assign sum_zero  = (iv_sum == '0);

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_beat    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    // output slot can take a new result this cycle
    assign out_free  = !m_valid_reg || m_ready;

    // an edge beat in PH_THIRD with a nonzero sum kicks off the division
    assign div_req.start = s_beat && (phase_reg == PH_THIRD) && !sum_zero;

    cefm_div #(
        .DVS_W (SUM_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (div_req),
        .dividend (clock_hz_reg),
        .divisor  (iv_sum),
        .stat     (div_stat),
        .quotient (div_quot)
    );

    always_comb begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        last_ts_next   = last_ts_reg;
        first_iv_next  = first_iv_reg;
        clock_hz_next  = clock_hz_reg;
        zero_pend_next = zero_pend_reg;
        m_valid_next   = m_valid_reg;
        m_freq_next    = m_freq_reg;
        m_zero_next    = m_zero_reg;

        if (cfg_valid && cfg_ready) begin
            clock_hz_next = cfg_data;
        end

        // result taken by the sink
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_beat) begin
                    last_ts_next = cap_w;
                    case (phase_reg)
                        PH_SECOND: begin
                            first_iv_next = cap_w - last_ts_reg;
                            phase_next    = PH_THIRD;
                        end
                        PH_THIRD: begin
                            phase_next     = PH_FIRST;
                            zero_pend_next = sum_zero;
                            state_next     = sum_zero ? ST_OUT : ST_DIV;
                        end
                        // first phase, and the unused code
                        default: begin
                            phase_next = PH_SECOND;
                        end
                    endcase
                end
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    // halve the quotient: floor(floor(a/s)/2)
                    m_freq_next  = zero_pend_reg ? '0 : div_quot[CLK_W-1:1];
                    m_zero_next  = zero_pend_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        m_freq_reg <= m_freq_next;
        m_zero_reg <= m_zero_next;
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_FIRST;
            last_ts_reg   <= '0;
            first_iv_reg  <= '0;
            clock_hz_reg  <= CLOCK_RESET;
            zero_pend_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            last_ts_reg   <= last_ts_next;
            first_iv_reg  <= first_iv_next;
            clock_hz_reg  <= clock_hz_next;
            zero_pend_reg <= zero_pend_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_frequency_hz  = m_freq_reg;
    assign m_zero_interval = m_zero_reg;

    a_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.done |-> state_reg == ST_DIV)
        else $error("divider result outside division state");

    a_busy_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.busy |-> !s_ready)
        else $error("capture accepted while dividing");

    a_zero_means_no_freq: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_zero_reg |-> m_freq_reg == '0)
        else $error("zero interval result with nonzero frequency");

    a_load_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_OUT))
        else $error("result raised outside output state");

    a_third_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        s_beat && phase_reg == PH_THIRD |=> phase_reg == PH_FIRST && state_reg != ST_IDLE)
        else $error("third edge did not start a result");

endmodule
